### rtl/tmavg_pkg.sv
// Shared types and constants for the temperature moving-average unit.
`timescale 1ns / 1ps
`default_nettype none

package tmavg_pkg;

  // ring depth and derived widths
  localparam int Window   = 10;
  localparam int SampleW  = 15;
  localparam int SlotW    = $clog2(Window);
  localparam int CntW     = $clog2(Window + 1);
  localparam int SumW     = SampleW + $clog2(Window);
  localparam int MagW     = SumW - 1;
  localparam int DivSteps = (MagW + 1) / 2;
  localparam int DivW     = 2 * DivSteps;
  localparam int StepW    = $clog2(DivSteps);

  // input field widths
  localparam int WholeW = 8;
  localparam int MicroW = 21;

  // micro / 10000 via reciprocal: floor(x * RecipMul / 2^RecipShift), exact for |x| <= 2^20
  localparam int RecipShift = 34;
  localparam logic [MicroW-1:0] RecipMul = MicroW'(1717987);
  localparam int QuotW      = 7;
  localparam int ProdW      = 2 * MicroW;

  localparam logic signed [SampleW-1:0] CentiPerDegree = SampleW'(100);
  localparam logic signed [SampleW-1:0] CentiMax       = 15'sh3fff;
  localparam logic signed [SampleW-1:0] CentiMin       = 15'sh4000;

  typedef struct packed {
    logic capture;
    logic conv;
    logic make_sample;
    logic accum;
    logic prep;
    logic div_step;
    logic out_load;
  } tmavg_cmd_t;

  typedef struct packed {
    logic div_last;
  } tmavg_stat_t;

endpackage

`default_nettype wire

### rtl/temperature_moving_average_min_max_unit.sv
// Top level of the temperature moving-average unit with min/max tracking.
//
// Input channel: in_valid/in_ready carry one reading per request as
// whole_degrees (signed) and micro_degrees (signed millionths). Output
// channel: out_valid/out_ready carry average_centi, lowest_centi and
// highest_centi in hundredths of a degree, one result per input request.
// The average covers the last ten samples, or fewer right after reset.
// From input accept to result valid the steps are: conversion multiply,
// sample build, ring update, divider load, the two-bit-per-cycle restoring
// divider by the fill count, then the output load. A new reading is taken
// only once the previous one has been loaded into the output register.
// The result sits in an output register, so the next reading is accepted
// while a result waits; if the receiver still stalls when the next result
// is ready, the unit holds it and accepts no further reading until then.
// Reset (rst, synchronous) empties the ring, clears the sum and sets the
// tracked minimum to +16383 and maximum to -16384 hundredths.
`timescale 1ns / 1ps
`default_nettype none

module temperature_moving_average_min_max_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [tmavg_pkg::WholeW-1:0] whole_degrees,
  input  wire logic signed [tmavg_pkg::MicroW-1:0] micro_degrees,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [tmavg_pkg::SampleW-1:0]     average_centi,
  output logic signed [tmavg_pkg::SampleW-1:0]     lowest_centi,
  output logic signed [tmavg_pkg::SampleW-1:0]     highest_centi
);

  tmavg_pkg::tmavg_cmd_t  cmd;
  tmavg_pkg::tmavg_stat_t stat;

  tmavg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tmavg_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .whole_degrees (whole_degrees),
    .micro_degrees (micro_degrees),
    .average_centi (average_centi),
    .lowest_centi  (lowest_centi),
    .highest_centi (highest_centi)
  );

endmodule

`default_nettype wire

### rtl/tmavg_ctrl.sv
// Sequencing state machine for the temperature moving-average unit.
`timescale 1ns / 1ps
`default_nettype none

module tmavg_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tmavg_pkg::tmavg_cmd_t      cmd,
  input  wire tmavg_pkg::tmavg_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CONV   = 7'b0000010,
    S_SAMPLE = 7'b0000100,
    S_ACCUM  = 7'b0001000,
    S_PREP   = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv   = 1'b1;
        state_next = S_SAMPLE;
      end
      S_SAMPLE: begin
        cmd.make_sample = 1'b1;
        state_next      = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        // hold the new result until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result valid raised outside completion");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

### rtl/tmavg_dp.sv
// Datapath: reading conversion, sample ring, running sum, divider, min/max.
`timescale 1ns / 1ps
`default_nettype none

module tmavg_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tmavg_pkg::tmavg_cmd_t                 cmd,
  output tmavg_pkg::tmavg_stat_t                     stat,
  input  wire logic signed [tmavg_pkg::WholeW-1:0]   whole_degrees,
  input  wire logic signed [tmavg_pkg::MicroW-1:0]   micro_degrees,
  output logic signed [tmavg_pkg::SampleW-1:0]       average_centi,
  output logic signed [tmavg_pkg::SampleW-1:0]       lowest_centi,
  output logic signed [tmavg_pkg::SampleW-1:0]       highest_centi
);

  localparam int SampleW = tmavg_pkg::SampleW;
  localparam int SumW    = tmavg_pkg::SumW;
  localparam int MagW    = tmavg_pkg::MagW;
  localparam int DivW    = tmavg_pkg::DivW;
  localparam int CntW    = tmavg_pkg::CntW;
  localparam int SlotW   = tmavg_pkg::SlotW;
  localparam int StepW   = tmavg_pkg::StepW;
  localparam int QuotW   = tmavg_pkg::QuotW;
  localparam int MicroW  = tmavg_pkg::MicroW;
  localparam int WholeW  = tmavg_pkg::WholeW;
  localparam int ProdW   = tmavg_pkg::ProdW;

  logic [SampleW-1:0] ring [tmavg_pkg::Window];

  logic signed [WholeW-1:0]  whole_q;
  logic signed [MicroW-1:0]  micro_q;
  logic [QuotW-1:0]          frac_mag;
  logic [SampleW-1:0]        old_sample;
  logic signed [SampleW-1:0] sample;
  logic signed [SumW-1:0]    sum, sum_next;
  logic [DivW-1:0]           dvd, dvd_next;
  logic [CntW-1:0]           rem, rem_next;
  logic                      neg;
  logic [StepW-1:0]          step;
  logic [SlotW-1:0]          write_slot;
  logic [CntW-1:0]           fill_count;
  logic signed [SampleW-1:0] running_low, running_high;

  logic [MicroW-1:0]         micro_mag;
  logic [ProdW-1:0]          prod;
  logic signed [SampleW-1:0] whole_scaled;
  logic signed [SampleW-1:0] frac_signed;
  logic signed [SampleW-1:0] sample_next;
  logic                      full;
  logic [MagW-1:0]           sum_mag;
  logic [SampleW-1:0]        quot;
  logic signed [SampleW-1:0] avg_next;

  // reading conversion: whole*100 + trunc(micro/10000)
  assign micro_mag    = micro_q[MicroW-1] ? MicroW'(-micro_q) : MicroW'(micro_q);
  assign prod         = ProdW'(micro_mag) * ProdW'(tmavg_pkg::RecipMul);
  assign whole_scaled = SampleW'(whole_q) * tmavg_pkg::CentiPerDegree;
  assign frac_signed  = micro_q[MicroW-1] ? -SampleW'(frac_mag) : SampleW'(frac_mag);
  assign sample_next  = whole_scaled + frac_signed;

  // once the ring is full the evicted sample leaves the sum
  assign full     = (fill_count == CntW'(tmavg_pkg::Window));
  assign sum_next = full ? sum + SumW'(sample) - SumW'($signed(old_sample))
                         : sum + SumW'(sample);
  assign sum_mag  = sum[SumW-1] ? MagW'(-sum) : MagW'(sum);

  // two restoring divide steps per cycle
  always_comb begin
    logic [CntW-1:0] r;
    logic [DivW-1:0] t;
    logic [CntW:0]   sh;
    r = rem;
    t = dvd;
    for (int k = 0; k < 2; k++) begin
      sh = {r, t[DivW-1]};
      t  = {t[DivW-2:0], 1'b0};
      if (sh >= {1'b0, fill_count}) begin
        sh   = sh - {1'b0, fill_count};
        t[0] = 1'b1;
      end
      r = sh[CntW-1:0];
    end
    rem_next = r;
    dvd_next = t;
  end

  assign quot     = dvd[SampleW-1:0];
  assign avg_next = neg ? -$signed(quot) : $signed(quot);

  assign stat.div_last = (step == StepW'(tmavg_pkg::DivSteps - 1));

  // sample ring, registered read
  always_ff @(posedge clk) begin
    if (cmd.conv) old_sample <= ring[write_slot];
    if (cmd.accum) ring[write_slot] <= sample;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      whole_q <= whole_degrees;
      micro_q <= micro_degrees;
    end
    if (cmd.conv) frac_mag <= prod[tmavg_pkg::RecipShift +: QuotW];
    if (cmd.make_sample) sample <= sample_next;
    if (cmd.prep) begin
      dvd <= DivW'(sum_mag);
      rem <= '0;
      neg <= sum[SumW-1];
    end else if (cmd.div_step) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
    if (cmd.out_load) average_centi <= avg_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      write_slot   <= '0;
      fill_count   <= '0;
      step         <= '0;
      running_low  <= tmavg_pkg::CentiMax;
      running_high <= tmavg_pkg::CentiMin;
    end else begin
      if (cmd.accum) begin
        sum        <= sum_next;
        write_slot <= (write_slot == SlotW'(tmavg_pkg::Window - 1)) ? '0 : write_slot + 1'b1;
        if (!full) fill_count <= fill_count + 1'b1;
      end
      if (cmd.prep) step <= '0;
      else if (cmd.div_step) step <= step + 1'b1;
      if (cmd.out_load) begin
        if (avg_next < running_low) running_low <= avg_next;
        if (avg_next > running_high) running_high <= avg_next;
      end
    end
  end

  assign lowest_centi  = running_low;
  assign highest_centi = running_high;

  a_ring_bounds: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CntW'(tmavg_pkg::Window) && write_slot < SlotW'(tmavg_pkg::Window))
    else $error("ring pointer or fill count out of range");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> rem < fill_count)
    else $error("divider remainder not below fill count");

  a_low_le_high: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> running_low <= running_high
      && running_low <= average_centi && average_centi <= running_high)
    else $error("running min/max inconsistent with average");

endmodule

`default_nettype wire

### tb/temperature_moving_average_min_max_unit_tb.sv
// Testbench for the temperature moving-average unit: directed table, random readings, predictor.
`timescale 1ns / 1ps

module temperature_moving_average_min_max_unit_tb;

  localparam int SampleW      = tmavg_pkg::SampleW;
  localparam int WholeW       = tmavg_pkg::WholeW;
  localparam int MicroW       = tmavg_pkg::MicroW;
  localparam int Window       = tmavg_pkg::Window;
  localparam int NumDirected  = 20;
  localparam int NumRandom    = 1400;
  localparam int DrainAt      = 700;
  localparam int QuietAt      = 1250;
  localparam int CentiPerDeg  = 100;
  localparam int MicroPerCent = 10000;

  typedef struct packed {
    logic signed [SampleW-1:0] avg;
    logic signed [SampleW-1:0] low;
    logic signed [SampleW-1:0] high;
  } centi_result_t;

  typedef struct packed {
    logic signed [WholeW-1:0] whole;
    logic signed [MicroW-1:0] micro;
    bit                       typed;
    centi_result_t            want;
  } reading_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [WholeW-1:0]    whole_degrees = '0;
  logic signed [MicroW-1:0]    micro_degrees = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SampleW-1:0]   average_centi;
  logic signed [SampleW-1:0]   lowest_centi;
  logic signed [SampleW-1:0]   highest_centi;

  temperature_moving_average_min_max_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .whole_degrees (whole_degrees),
    .micro_degrees (micro_degrees),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .average_centi (average_centi),
    .lowest_centi  (lowest_centi),
    .highest_centi (highest_centi)
  );

  always #6 clk = ~clk;

  // only the first three rows have values typed in; the rest go through the predictor
  reading_row_t directed_rows [NumDirected] = '{
    '{8'sd0,    21'sd0,        1'b1, '{15'sd0,    15'sd0,    15'sd0}},
    '{8'sd127,  21'sd999999,   1'b1, '{15'sd6399, 15'sd0,    15'sd6399}},
    '{-8'sd128, -21'sd999999,  1'b1, '{-15'sd33,  -15'sd33,  15'sd6399}},
    '{8'sd127,  21'sd1048575,  1'b0, '0},
    '{-8'sd128, -21'sd1048576, 1'b0, '0},
    '{8'sd5,    -21'sd500000,  1'b0, '0},
    '{-8'sd5,   21'sd500000,   1'b0, '0},
    '{8'sd0,    21'sd9999,     1'b0, '0},
    '{8'sd0,    -21'sd9999,    1'b0, '0},
    '{8'sd0,    21'sd10000,    1'b0, '0},
    '{8'sd0,    -21'sd10000,   1'b0, '0},
    '{-8'sd128, 21'sd1048575,  1'b0, '0},
    '{8'sd127,  -21'sd1048576, 1'b0, '0},
    '{8'sd127,  21'sd999999,   1'b0, '0},
    '{8'sd1,    -21'sd1,       1'b0, '0},
    '{-8'sd1,   21'sd1,        1'b0, '0},
    '{8'sd100,  21'sd0,        1'b0, '0},
    '{-8'sd100, -21'sd123456,  1'b0, '0},
    '{8'sd0,    21'sd1048575,  1'b0, '0},
    '{8'sd0,    -21'sd1048576, 1'b0, '0}
  };

  // predictor state
  int ring_centi [Window];
  int next_slot  = 0;
  int held_count = 0;
  int low_centi  = 16383;
  int high_centi = -16384;

  centi_result_t pending_centi [$];
  int            mismatches = 0;
  bit            quiet = 1'b0;
  int            stall_left = 0;

  function automatic centi_result_t advance_window(input logic signed [WholeW-1:0] w,
                                                   input logic signed [MicroW-1:0] m);
    int            sample;
    int            mean;
    longint        total;
    centi_result_t r;
    sample = int'(w) * CentiPerDeg + int'(m) / MicroPerCent;
    ring_centi[next_slot] = sample;
    next_slot = (next_slot + 1) % Window;
    if (held_count < Window) held_count++;
    total = 0;
    for (int i = 0; i < held_count; i++) total += ring_centi[i];
    mean = int'(total / longint'(held_count));
    if (mean < low_centi) low_centi = mean;
    if (mean > high_centi) high_centi = mean;
    r.avg  = SampleW'(mean);
    r.low  = SampleW'(low_centi);
    r.high = SampleW'(high_centi);
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic issue_reading(input logic signed [WholeW-1:0] w,
                               input logic signed [MicroW-1:0] m,
                               input bit typed, input centi_result_t typed_want);
    centi_result_t predicted;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    whole_degrees <= w;
    micro_degrees <= m;
    do @(posedge clk); while (!in_ready);
    predicted = advance_window(w, m);
    pending_centi.push_back(typed ? typed_want : predicted);
  endtask

  initial begin
    int                       random_sent;
    int                       pick;
    int                       burst;
    int                       plateau;
    int                       mag;
    int                       offset;
    logic signed [WholeW-1:0] w;
    logic signed [MicroW-1:0] m;
    random_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumDirected; i++)
      issue_reading(directed_rows[i].whole, directed_rows[i].micro,
                    directed_rows[i].typed, directed_rows[i].want);

    while (random_sent < NumRandom) begin
      pick    = $urandom_range(0, 9);
      burst   = (pick >= 8) ? $urandom_range(8, 14) : 1;
      plateau = $urandom_range(0, 3);
      repeat (burst) begin
        if (pick >= 8) begin
          // long runs of one extreme reading can fill the ring and push the min/max to the edges
          case (plateau)
            0:       begin w = 8'sd127;  m = 21'sd999999;   end
            1:       begin w = -8'sd128; m = -21'sd999999;  end
            2:       begin w = 8'sd127;  m = 21'sd1048575;  end
            default: begin w = -8'sd128; m = -21'sd1048576; end
          endcase
        end else if (pick == 7) begin
          // micro parts right at the truncation steps
          mag    = $urandom_range(0, 104) * MicroPerCent;
          offset = $urandom_range(0, 2);
          mag    = mag + offset - 1;
          if (mag > 1048575) mag = 1048575;
          w = WholeW'($urandom);
          m = MicroW'($urandom_range(0, 1) ? -mag : mag);
        end else if (pick >= 5) begin
          w = WholeW'($urandom);
          m = MicroW'($urandom);
        end else begin
          w   = WholeW'($urandom_range(0, 255));
          mag = $urandom_range(0, 999999);
          if (w < 0 || (w == 0 && $urandom_range(0, 1) == 1))
            m = MicroW'(-mag);
          else
            m = MicroW'(mag);
        end
        issue_reading(w, m, 1'b0, '0);
        random_sent++;
        if (random_sent == DrainAt) begin
          in_valid <= 1'b0;
          while (pending_centi.size() != 0) @(posedge clk);
        end
        if (random_sent == QuietAt) quiet = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (pending_centi.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_centi.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    centi_result_t want;
    logic          next_ready;
    if (!rst && out_valid && out_ready) begin
      if (pending_centi.size() == 0) begin
        $display("%0t: unexpected result avg %0d low %0d high %0d", $time,
                 average_centi, lowest_centi, highest_centi);
        mismatches++;
      end else begin
        want = pending_centi.pop_front();
        if (average_centi !== want.avg) begin
          $display("%0t: average_centi expected %0d actual %0d", $time,
                   $signed(want.avg), average_centi);
          mismatches++;
        end
        if (lowest_centi !== want.low) begin
          $display("%0t: lowest_centi expected %0d actual %0d", $time,
                   $signed(want.low), lowest_centi);
          mismatches++;
        end
        if (highest_centi !== want.high) begin
          $display("%0t: highest_centi expected %0d actual %0d", $time,
                   $signed(want.high), highest_centi);
          mismatches++;
        end
      end
    end
    if (quiet) begin
      next_ready = 1'b1;
    end else if (stall_left > 0) begin
      next_ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      next_ready = 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      next_ready = 1'b1;
    end
    out_ready <= next_ready;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
